/* rtl/core/xalu_pkg.sv */
// Package: opcodes, widths, controller types for the x86 integer ALU.
package xalu_pkg;
   localparam int MAX_WIDTH_DEFAULT = 32;
   localparam int DIV_STEPS = 64;

   localparam logic [3:0] OP_ADD  = 4'd0;
   localparam logic [3:0] OP_ADC  = 4'd1;
   localparam logic [3:0] OP_SUB  = 4'd2;
   localparam logic [3:0] OP_SBB  = 4'd3;
   localparam logic [3:0] OP_AND  = 4'd4;
   localparam logic [3:0] OP_OR   = 4'd5;
   localparam logic [3:0] OP_XOR  = 4'd6;
   localparam logic [3:0] OP_SHL  = 4'd7;
   localparam logic [3:0] OP_SHR  = 4'd8;
   localparam logic [3:0] OP_SAR  = 4'd9;
   localparam logic [3:0] OP_MUL  = 4'd10;
   localparam logic [3:0] OP_IMUL = 4'd11;
   localparam logic [3:0] OP_DIV  = 4'd12;
   localparam logic [3:0] OP_IDIV = 4'd13;
   localparam logic [3:0] OP_MOD  = 4'd14;

   localparam logic [1:0] WC_8  = 2'd0;
   localparam logic [1:0] WC_16 = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXEC, ST_MUL, ST_DIV, ST_DIVFIN, ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic mul_fin;
      logic div_start;
      logic div_step;
      logic div_fin;
   } cmd_type;

   typedef struct packed {
      logic is_mul;
      logic is_div;
      logic div_zero;
      logic div_last;
   } stat_type;
endpackage

/* rtl/core/x86_integer_alu_with_flags.sv */
// Top level: x86 integer ALU with kept CF, PF, SF, ZF and OF flags.
// Usage:
//  - Request channel (req_valid/req_ready) takes one word: opcode, width
//    code, source and 64-bit dest operands, signed-remainder select.
//  - Response channel (rsp_valid/rsp_ready) returns result, five flags and
//    divide_error. One response word per request word, in order.
//  - States from request accept to response: add/logic/shift pass EXEC,
//    OUT; mul/imul pass EXEC, MUL, OUT; div/idiv/mod pass EXEC, DIV (64
//    steps of the one-bit-per-cycle restoring divider), DIVFIN, OUT; a
//    zero divisor goes from EXEC to OUT. One word is in flight at a time;
//    the next request is taken the cycle after the response is accepted.
//  - A stalled receiver holds the response word steady until taken.
//  - Reset clears the flags to zero and returns the controller to idle.
module x86_integer_alu_with_flags import xalu_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_opcode,
   input  logic [1:0]  req_width_code,
   input  logic [31:0] req_source_operand,
   input  logic [63:0] req_dest_operand,
   input  logic        req_signed_remainder,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_result,
   output logic        rsp_carry_out,
   output logic        rsp_parity_out,
   output logic        rsp_sign_out,
   output logic        rsp_zero_out,
   output logic        rsp_overflow_out,
   output logic        rsp_divide_error
);
   cmd_type  cmd;
   stat_type stat;

   xalu_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .stat(stat), .cmd(cmd)
   );

   xalu_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_opcode(req_opcode), .req_width_code(req_width_code),
      .req_source_operand(req_source_operand), .req_dest_operand(req_dest_operand),
      .req_signed_remainder(req_signed_remainder),
      .rsp_result(rsp_result), .rsp_carry_out(rsp_carry_out),
      .rsp_parity_out(rsp_parity_out), .rsp_sign_out(rsp_sign_out),
      .rsp_zero_out(rsp_zero_out), .rsp_overflow_out(rsp_overflow_out),
      .rsp_divide_error(rsp_divide_error)
   );
endmodule

/* rtl/core/xalu_ctrl.sv */
// Controller: sequences load, execute, multiply, divide and result handshake.
module xalu_ctrl import xalu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (stat.is_mul) state_in = ST_MUL;
            else if (stat.is_div && !stat.div_zero) begin
               cmd.div_start = 1'b1;
               state_in = ST_DIV;
            end else begin
               cmd.exec = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_MUL: begin
            cmd.mul_fin = 1'b1;
            state_in = ST_OUT;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = ST_DIVFIN;
         end
         ST_DIVFIN: begin
            cmd.div_fin = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

/* rtl/core/xalu_dp.sv */
// Datapath: operand registers, ALU, shifter, multiplier, serial divider, flags.
module xalu_dp import xalu_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [3:0]  req_opcode,
   input  logic [1:0]  req_width_code,
   input  logic [31:0] req_source_operand,
   input  logic [63:0] req_dest_operand,
   input  logic        req_signed_remainder,
   output logic [63:0] rsp_result,
   output logic        rsp_carry_out,
   output logic        rsp_parity_out,
   output logic        rsp_sign_out,
   output logic        rsp_zero_out,
   output logic        rsp_overflow_out,
   output logic        rsp_divide_error
);
   logic [3:0]  op_ff;
   logic [1:0]  wc_ff;
   logic [31:0] src_ff;
   logic [63:0] dst_ff;
   logic        srem_ff;
   logic [4:0]  flags_ff, flags_in;
   logic [63:0] res_ff, res_in;
   logic        derr_ff, derr_in;
   logic [63:0] prod_ff;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] dvs_ff;
   logic [5:0]  cnt_ff, cnt_in;
   logic        nn_ff, nq_ff;

   logic [5:0]  w;
   logic [63:0] m, m2, s, d, sx, dx;
   logic signed [63:0] sprod;
   logic [5:0]  sh;
   logic        is_signed;

   always_comb begin
      w = (wc_ff == WC_8) ? 6'd8 : (wc_ff == WC_16) ? 6'd16 : 6'd32;
      if (w > 6'(MAX_WIDTH)) w = 6'(MAX_WIDTH);
      m  = (64'd1 << w) - 64'd1;
      m2 = (w == 6'd32) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << {w, 1'b0}) - 64'd1);
      s  = {32'd0, src_ff} & m;
      d  = dst_ff & m;
      sx = s[w - 6'd1] ? (s | ~m) : s;
      dx = d[w - 6'd1] ? (d | ~m) : d;
      sprod = $signed(dx[31:0]) * $signed(sx[31:0]);
      sh = src_ff[5:0];
      is_signed = (op_ff == OP_IDIV) || (op_ff == OP_MOD && srem_ff);
      stat.is_mul   = (op_ff == OP_MUL) || (op_ff == OP_IMUL);
      stat.is_div   = (op_ff == OP_DIV) || (op_ff == OP_IDIV) || (op_ff == OP_MOD);
      stat.div_zero = (s == 64'd0);
      stat.div_last = (cnt_ff == 6'(DIV_STEPS - 1));
   end

   function automatic logic [4:0] szp(input logic [4:0] f, input logic [63:0] r,
                                      input logic [63:0] mk, input logic [5:0] wd);
      logic [63:0] v;
      logic [4:0]  o;
      v = r & mk;
      o = f;
      o[1] = ~(^v[7:0]);
      o[2] = v[wd - 6'd1];
      o[3] = (v == 64'd0);
      return o;
   endfunction

   logic [64:0] sum;
   logic [63:0] t;
   logic [63:0] rem_sh, dif;
   logic [64:0] trial;
   logic [63:0] qmag, rmag;

   always_comb begin
      flags_in = flags_ff;
      res_in = res_ff;
      derr_in = derr_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      sum = '0;
      t = '0;
      rem_sh = {rem_ff[62:0], quo_ff[63]};
      trial = {1'b0, rem_sh} - {1'b0, dvs_ff};
      dif = trial[63:0];
      qmag = nq_ff ? (64'd0 - quo_ff) : quo_ff;
      rmag = nn_ff ? (64'd0 - rem_ff) : rem_ff;
      if (cmd.exec) begin
         derr_in = 1'b0;
         case (op_ff)
            OP_ADD, OP_ADC: begin
               sum = {1'b0, d} + {1'b0, s} +
                     65'((op_ff == OP_ADC) ? flags_ff[0] : 1'b0);
               res_in = sum[63:0] & m;
               flags_in[0] = sum[w];
               flags_in[4] = ((d ^ res_in) & (s ^ res_in)) >> (w - 6'd1) != 64'd0;
               flags_in = szp(flags_in, res_in, m, w);
            end
            OP_SUB, OP_SBB: begin
               sum = {1'b0, d} - {1'b0, s} -
                     65'((op_ff == OP_SBB) ? flags_ff[0] : 1'b0);
               res_in = sum[63:0] & m;
               flags_in[0] = sum[64];
               flags_in[4] = ((d ^ s) & (d ^ res_in)) >> (w - 6'd1) != 64'd0;
               flags_in = szp(flags_in, res_in, m, w);
            end
            OP_AND, OP_OR, OP_XOR: begin
               res_in = (op_ff == OP_AND) ? (d & s) : (op_ff == OP_OR) ? (d | s) : (d ^ s);
               flags_in[0] = 1'b0;
               flags_in[4] = 1'b0;
               flags_in = szp(flags_in, res_in, m, w);
            end
            OP_SHL: begin
               res_in = (d << sh) & m;
               if (sh != 6'd0) begin
                  t = d << (sh - 6'd1);
                  flags_in[0] = t[w - 6'd1];
                  flags_in = szp(flags_in, res_in, m, w);
               end
            end
            OP_SHR: begin
               res_in = d >> sh;
               if (sh != 6'd0) begin
                  t = d >> (sh - 6'd1);
                  flags_in[0] = t[0];
                  flags_in = szp(flags_in, res_in, m, w);
               end
            end
            OP_SAR: begin
               res_in = 64'($signed(dx) >>> ((sh > w) ? w : sh)) & m;
               if (sh != 6'd0) begin
                  t = 64'($signed(dx) >>> (sh - 6'd1));
                  flags_in[0] = t[0];
                  flags_in = szp(flags_in, res_in, m, w);
               end
            end
            OP_DIV, OP_IDIV, OP_MOD: begin
               res_in = 64'd0;
               derr_in = 1'b1;
            end
            default: res_in = 64'd0;
         endcase
      end
      if (cmd.mul_fin) begin
         derr_in = 1'b0;
         res_in = prod_ff & m2;
         if (op_ff == OP_MUL)
            flags_in[0] = ((prod_ff & m2) >> w) != 64'd0;
         else
            flags_in[0] = ((prod_ff[w - 6'd1] ? (prod_ff | ~m) : (prod_ff & m))
                           != prod_ff);
         flags_in[4] = flags_in[0];
         flags_in = szp(flags_in, res_in, m, w);
      end
      if (cmd.div_start) begin
         quo_in = (is_signed && dst_ff[63]) ? (64'd0 - dst_ff) : dst_ff;
         rem_in = 64'd0;
         cnt_in = 6'd0;
      end
      if (cmd.div_step) begin
         if (!trial[64]) begin
            rem_in = dif;
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
      end
      if (cmd.div_fin) begin
         derr_in = 1'b0;
         res_in = ((op_ff == OP_MOD) ? rmag : qmag) & m;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) flags_ff <= 5'd0;
      else flags_ff <= flags_in;
      if (cmd.load) begin
         op_ff <= req_opcode;
         wc_ff <= req_width_code;
         src_ff <= req_source_operand;
         dst_ff <= req_dest_operand;
         srem_ff <= req_signed_remainder;
      end
      if (stat.is_mul)
         prod_ff <= (op_ff == OP_MUL) ? (d[31:0] * s[31:0]) : sprod;
      if (cmd.div_start) begin
         dvs_ff <= is_signed ? (sx[63] ? (64'd0 - sx) : sx) : s;
         nn_ff <= is_signed && dst_ff[63];
         nq_ff <= is_signed && (dst_ff[63] != sx[63]);
      end
      res_ff <= res_in;
      derr_ff <= derr_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign rsp_result = res_ff;
   assign rsp_carry_out = flags_ff[0];
   assign rsp_parity_out = flags_ff[1];
   assign rsp_sign_out = flags_ff[2];
   assign rsp_zero_out = flags_ff[3];
   assign rsp_overflow_out = flags_ff[4];
   assign rsp_divide_error = derr_ff;
endmodule
